// ===== rtl/msdh_pkg.sv =====
// Shared constants and a helper function for the mid-square decimal hash.
package msdh_pkg;

    localparam int KEY_PORT_W  = 16;
    localparam int KEY_W_DEF   = 16;
    localparam int IDX_W       = 10;
    localparam int CNT_DIG_W   = 4;
    localparam int BCD_W       = 4;
    localparam int MID_DIGITS  = 3;
    localparam int SHORT_LIMIT = 3;

    // decimal digits needed for an unsigned value of the given bit width
    function automatic int dec_digits(input int bits);
        int res;
        res = (bits * 30103) / 100000 + 1;
        return res;
    endfunction

endpackage

// ===== rtl/msdh_dabble.sv =====
// Bit-serial binary to BCD converter (shift and add-3).
module msdh_dabble #(
    parameter int SQ_W = 32,
    parameter int NDIG = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  logic [SQ_W-1:0]                 value,
    output logic [NDIG*msdh_pkg::BCD_W-1:0] bcd,
    output logic                            done
);

    localparam int BW    = NDIG * msdh_pkg::BCD_W;
    localparam int CNT_W = $clog2(SQ_W);

    logic [SQ_W-1:0]  bin_reg;
    logic [BW-1:0]    bcd_reg;
    logic [BW-1:0]    adj;
    logic [CNT_W-1:0] cnt_reg;
    logic             active_reg;
    logic             done_reg;

    genvar g;
    generate
        for (g = 0; g < NDIG; g++)
        begin : g_adj
            logic [msdh_pkg::BCD_W-1:0] dig;
            assign dig = bcd_reg[g*msdh_pkg::BCD_W +: msdh_pkg::BCD_W];
            assign adj[g*msdh_pkg::BCD_W +: msdh_pkg::BCD_W] =
                (dig >= 4'd5) ? dig + 4'd3 : dig;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= !load && active_reg && (cnt_reg == CNT_W'(SQ_W - 1));
            if (load)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQ_W - 1))
                    active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bin_reg <= value;
            bcd_reg <= '0;
        end
        else if (active_reg)
        begin
            bin_reg <= {bin_reg[SQ_W-2:0], 1'b0};
            bcd_reg <= {adj[BW-2:0], bin_reg[SQ_W-1]};
        end
    end

    assign bcd  = bcd_reg;
    assign done = done_reg;

endmodule

// ===== rtl/msdh_pick.sv =====
// Digit count, middle-digit select and BCD to binary of the three digits.
module msdh_pick #(
    parameter int NDIG = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             go,
    input  logic [NDIG*msdh_pkg::BCD_W-1:0]  bcd,
    output logic                             valid,
    output logic [msdh_pkg::IDX_W-1:0]       bucket_index,
    output logic [msdh_pkg::CNT_DIG_W-1:0]   square_digits
);

    localparam int BW  = NDIG * msdh_pkg::BCD_W;
    localparam int SW  = msdh_pkg::MID_DIGITS * msdh_pkg::BCD_W;
    localparam int DW  = msdh_pkg::CNT_DIG_W;
    localparam int IW  = msdh_pkg::IDX_W;

    logic [DW-1:0] d;
    logic [DW-1:0] lp;
    logic [BW-1:0] shifted;
    logic [SW-1:0] sel_reg;
    logic [DW-1:0] d_reg;
    logic          v1_reg;
    logic [IW-1:0] idx;
    logic [IW-1:0] idx_reg;
    logic [DW-1:0] dig_out_reg;
    logic          valid_reg;

    always_comb
    begin
        d = DW'(1);
        for (int i = 1; i < NDIG; i++)
        begin
            if (bcd[i*msdh_pkg::BCD_W +: msdh_pkg::BCD_W] != '0)
                d = DW'(i + 1);
        end
        if (d > DW'(msdh_pkg::SHORT_LIMIT))
            lp = d - {1'b0, d[DW-1:1]} - DW'(2);
        else
            lp = '0;
        shifted = bcd >> {lp, 2'b00};
    end

    always_comb
    begin
        idx = IW'(sel_reg[11:8]) * IW'(100)
            + IW'(sel_reg[7:4]) * IW'(10)
            + IW'(sel_reg[3:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= go;
            valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            sel_reg <= shifted[SW-1:0];
            d_reg   <= d;
        end
        if (v1_reg)
        begin
            idx_reg     <= idx;
            dig_out_reg <= d_reg;
        end
    end

    assign valid         = valid_reg;
    assign bucket_index  = idx_reg;
    assign square_digits = dig_out_reg;

endmodule

// ===== rtl/mid_square_decimal_hash.sv =====
// Top level of the mid-square decimal hash.
// Usage:
//   A transaction is taken at a rising edge with start high and busy low;
//   key_value is sampled then, and only its low KEY_WIDTH bits are used.
//   The key is squared in one registered multiply, the square is turned
//   into BCD one bit per cycle, then the digit count and the three middle
//   digits are picked out and converted back to binary.
//   done is high for exactly one cycle with bucket_index and square_digits
//   valid in that cycle; the receiver cannot stall the block.
// Sequence: after the accepting edge the square is loaded into the converter,
//   the 2*KEY_WIDTH-bit square is converted to BCD bit-serially, then the
//   selected digits are registered, then the index, and done rises.
// Only one key is in flight at a time; busy falls the cycle
//   after done.
// Reset: rst_n clears the control state; the block comes up idle with
//   busy and done low.
module mid_square_decimal_hash #(
    parameter int KEY_WIDTH = msdh_pkg::KEY_W_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [msdh_pkg::KEY_PORT_W-1:0]    key_value,
    output logic                               done,
    output logic [msdh_pkg::IDX_W-1:0]         bucket_index,
    output logic [msdh_pkg::CNT_DIG_W-1:0]     square_digits
);

    localparam int SQ_W = 2 * KEY_WIDTH;
    localparam int NDIG = msdh_pkg::dec_digits(SQ_W);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SQUARE = 2'd1;
    localparam logic [1:0] ST_CONV   = 2'd2;
    localparam logic [1:0] ST_PICK   = 2'd3;

    logic [1:0]                       state_reg;
    logic [1:0]                       state_next;
    logic [KEY_WIDTH-1:0]             key_reg;
    logic [SQ_W-1:0]                  square;
    logic                             conv_load;
    logic                             conv_done;
    logic [NDIG*msdh_pkg::BCD_W-1:0]  bcd;
    logic                             pick_valid;

    assign square    = SQ_W'(key_reg) * SQ_W'(key_reg);
    assign conv_load = (state_reg == ST_SQUARE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (start) state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_CONV;
            ST_CONV:   if (conv_done) state_next = ST_PICK;
            ST_PICK:   if (pick_valid) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (start && (state_reg == ST_IDLE))
            key_reg <= key_value[KEY_WIDTH-1:0];
    end

    msdh_dabble #(
        .SQ_W (SQ_W),
        .NDIG (NDIG)
    ) u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (conv_load),
        .value (square),
        .bcd   (bcd),
        .done  (conv_done)
    );

    msdh_pick #(
        .NDIG (NDIG)
    ) u_pick (
        .clk           (clk),
        .rst_n         (rst_n),
        .go            (conv_done),
        .bcd           (bcd),
        .valid         (pick_valid),
        .bucket_index  (bucket_index),
        .square_digits (square_digits)
    );

    assign busy = (state_reg != ST_IDLE);
    assign done = pick_valid;

endmodule
